[design/dccd_pkg.sv]
// shared types and constants for the dcc capture packet decoder
// no dependencies; imported by every module of the block
package dccd_pkg;

	localparam int MAX_BYTES      = 7;
	localparam int TS_BITS        = 16;
	localparam int IDX_W          = $clog2(MAX_BYTES + 1);
	localparam int PKT_W          = 8 * MAX_BYTES;
	localparam int CFG_W          = 16;
	localparam int TOL_W          = 12;
	localparam int PRE_W          = 4;
	localparam int MIX_W          = 5;
	localparam int MINB_W         = 3;
	localparam int CNT_W          = 8;
	localparam int PH_W           = 4;

	// pulse classification codes
	typedef enum logic [1:0] {
		CLS_ZERO    = 2'd0,
		CLS_ONE     = 2'd1,
		CLS_MIXED   = 2'd2,
		CLS_INVALID = 2'd3
	} pulse_class_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_ONE_PERIOD   = 3'd0,
		REG_ZERO_PERIOD  = 3'd1,
		REG_MIXED_PERIOD = 3'd2,
		REG_TOLERANCE    = 3'd3,
		REG_PREAMBLE_MIN = 3'd4,
		REG_MIXED_LIMIT  = 3'd5,
		REG_MIN_BYTES    = 3'd6
	} reg_index_t;

	typedef enum logic [3:0] {
		FR_IDLE      = 4'b0001,
		FR_PREAMBLE  = 4'b0010,
		FR_SEPARATOR = 4'b0100,
		FR_DATA      = 4'b1000
	} frame_state_t;

	typedef struct packed {
		logic [TS_BITS-1:0] one_period;
		logic [TS_BITS-1:0] zero_period;
		logic [TS_BITS-1:0] mixed_period;
		logic [TOL_W-1:0]   tolerance;
		logic [PRE_W-1:0]   preamble_min;
		logic [MIX_W-1:0]   mixed_flip_limit;
		logic [MINB_W-1:0]  min_packet_bytes;
	} cfg_t;

	// latched packet store as seen after a beat
	typedef struct packed {
		logic              done;
		logic [IDX_W-1:0]  length;
		logic [PKT_W-1:0]  bytes;
		logic [CNT_W-1:0]  total;
	} pkt_status_t;

endpackage

[design/dcc_capture_packet_decoder.sv]
// dcc capture packet decoder top level: input register, classifier, framer, result register
// depends on dccd_pkg, dccd_classify, dccd_framer
// an accepted input beat passes through the input register, then the result register
// throughput: one beat per cycle while the receiver does not stall; the classify and framer
// step is combinational between the input register and the result register
// reset: arst_n clears config to defaults, framer to idle, latched packet, counters
module dcc_capture_packet_decoder
	import dccd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	// capture beats
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [TS_BITS-1:0] capture_time,
	// result beats
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         pulse_class,
	output logic               toggle_edge,
	output logic               packet_done,
	output logic [IDX_W-1:0]   packet_length,
	output logic [PKT_W-1:0]   packet_bytes,
	output logic [CNT_W-1:0]   packets_total
);

	cfg_t               cfg_q;
	logic               valid_s1;
	logic [TS_BITS-1:0] capture_s1;
	logic [TS_BITS-1:0] prev_q;
	logic [TS_BITS-1:0] diff;
	logic               advance;
	logic               load;
	pulse_class_t       cls;
	logic               toggle;
	pkt_status_t        status_nxt;

	// config registers; the user must write them only while the block is idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.one_period       <= TS_BITS'(1856);
			cfg_q.zero_period      <= TS_BITS'(3200);
			cfg_q.mixed_period     <= TS_BITS'(2528);
			cfg_q.tolerance        <= TOL_W'(100);
			cfg_q.preamble_min     <= PRE_W'(12);
			cfg_q.mixed_flip_limit <= MIX_W'(20);
			cfg_q.min_packet_bytes <= MINB_W'(3);
		end else if (cfg_wr_en) begin
			unique case (reg_index_t'(cfg_index))
				REG_ONE_PERIOD:   cfg_q.one_period       <= cfg_data[TS_BITS-1:0];
				REG_ZERO_PERIOD:  cfg_q.zero_period      <= cfg_data[TS_BITS-1:0];
				REG_MIXED_PERIOD: cfg_q.mixed_period     <= cfg_data[TS_BITS-1:0];
				REG_TOLERANCE:    cfg_q.tolerance        <= cfg_data[TOL_W-1:0];
				REG_PREAMBLE_MIN: cfg_q.preamble_min     <= cfg_data[PRE_W-1:0];
				REG_MIXED_LIMIT:  cfg_q.mixed_flip_limit <= cfg_data[MIX_W-1:0];
				REG_MIN_BYTES:    cfg_q.min_packet_bytes <= cfg_data[MINB_W-1:0];
				default: ;
			endcase
		end
	end

	// the s1 beat moves into the result register when that register is free or draining
	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) capture_s1 <= capture_time;
	end

	// modulo timestamp period from the previous capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (advance) begin
			prev_q <= capture_s1;
		end
	end

	assign diff = capture_s1 - prev_q;

	dccd_classify u_classify (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.diff   (diff),
		.cfg    (cfg_q),
		.cls    (cls),
		.toggle (toggle)
	);

	dccd_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.cls        (cls),
		.cfg        (cfg_q),
		.status_nxt (status_nxt)
	);

	// result register, holds while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pulse_class   <= cls;
			toggle_edge   <= toggle;
			packet_done   <= status_nxt.done;
			packet_length <= status_nxt.length;
			packet_bytes  <= status_nxt.bytes;
			packets_total <= status_nxt.total;
		end
	end

endmodule

[design/dccd_classify.sv]
// period classifier with tolerance windows and mixed period edge flip counter
// depends on dccd_pkg
module dccd_classify
	import dccd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic [TS_BITS-1:0] diff,
	input  cfg_t               cfg,
	output pulse_class_t       cls,
	output logic               toggle
);

	logic [MIX_W-1:0] mixed_count_q;
	logic [MIX_W-1:0] mixed_inc;
	logic             hit_one, hit_zero, hit_mixed;

	// lower bound clamps at zero, upper bound may pass the largest difference
	function automatic logic in_window(input logic [TS_BITS-1:0] d,
		input logic [TS_BITS-1:0] centre, input logic [TOL_W-1:0] tol);
		logic [TS_BITS-1:0] lo;
		logic [TS_BITS:0]   hi;
		lo = (centre > TS_BITS'(tol)) ? centre - TS_BITS'(tol) : '0;
		hi = {1'b0, centre} + (TS_BITS + 1)'(tol);
		return (d >= lo) && ({1'b0, d} <= hi);
	endfunction

	assign hit_one   = in_window(diff, cfg.one_period, cfg.tolerance);
	assign hit_zero  = in_window(diff, cfg.zero_period, cfg.tolerance);
	assign hit_mixed = in_window(diff, cfg.mixed_period, cfg.tolerance);

	always_comb begin
		priority if (hit_one) begin
			cls = CLS_ONE;
		end else if (hit_zero) begin
			cls = CLS_ZERO;
		end else if (hit_mixed) begin
			cls = CLS_MIXED;
		end else begin
			cls = CLS_INVALID;
		end
	end

	assign mixed_inc = mixed_count_q + MIX_W'(1);
	assign toggle    = (cls == CLS_MIXED) && (mixed_inc > cfg.mixed_flip_limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mixed_count_q <= '0;
		end else if (en && cls == CLS_MIXED) begin
			mixed_count_q <= toggle ? '0 : mixed_inc;
		end
	end

endmodule

[design/dccd_framer.sv]
// packet framer: preamble, start bit, msb-first bytes, separators, latched store
// depends on dccd_pkg
module dccd_framer
	import dccd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  pulse_class_t cls,
	input  cfg_t         cfg,
	output pkt_status_t  status_nxt
);

	localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_BYTES);
	localparam logic [PH_W-1:0]  BYTE_BITS = PH_W'(8);

	frame_state_t     state_q, state_d;
	logic [PH_W-1:0]  phase_q, phase_d, phase_inc;
	logic [IDX_W-1:0] bidx_q, bidx_d;
	logic [7:0]       asm_q [MAX_BYTES];
	logic [7:0]       asm_rd, asm_wdata;
	logic             asm_we;
	logic [IDX_W-1:0] len_q;
	logic [PKT_W-1:0] pkt_q;
	logic [CNT_W-1:0] cnt_q;
	logic             latch;
	logic [PKT_W-1:0] pkt_gather;

	assign phase_inc = phase_q + PH_W'(1);

	always_comb begin
		asm_rd = '0;
		for (int i = 0; i < MAX_BYTES; i++) begin
			if (bidx_q == IDX_W'(i)) asm_rd = asm_q[i];
		end
	end

	always_comb begin
		pkt_gather = '0;
		for (int i = 0; i < MAX_BYTES; i++) begin
			if (IDX_W'(i) < bidx_q) pkt_gather[8*i +: 8] = asm_q[i];
		end
	end

	assign asm_wdata = ((phase_q == '0) ? 8'd0 : {asm_rd[6:0], 1'b0})
		| {7'd0, cls == CLS_ONE};

	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		bidx_d  = bidx_q;
		asm_we  = 1'b0;
		latch   = 1'b0;
		if (cls == CLS_MIXED || cls == CLS_INVALID) begin
			state_d = FR_IDLE;
		end else begin
			unique case (state_q)
				FR_IDLE: begin
					if (cls == CLS_ONE) begin
						state_d = FR_PREAMBLE;
						phase_d = PH_W'(1);
					end
				end
				FR_PREAMBLE: begin
					if (cls == CLS_ONE) begin
						if (phase_q < cfg.preamble_min) phase_d = phase_inc;
					end else if (phase_q < cfg.preamble_min) begin
						state_d = FR_IDLE;
					end else begin
						state_d = FR_DATA;
						phase_d = '0;
						bidx_d  = '0;
					end
				end
				FR_SEPARATOR: begin
					if (cls == CLS_ZERO) begin
						if (bidx_q < MAX_IDX) begin
							state_d = FR_DATA;
							phase_d = '0;
						end else begin
							state_d = FR_IDLE;
						end
					end else begin
						// end bit
						latch   = 8'(bidx_q) >= 8'(cfg.min_packet_bytes);
						state_d = FR_IDLE;
					end
				end
				FR_DATA: begin
					if (bidx_q < MAX_IDX) begin
						asm_we  = 1'b1;
						phase_d = phase_inc;
						if (phase_inc == BYTE_BITS) begin
							state_d = FR_SEPARATOR;
							bidx_d  = bidx_q + IDX_W'(1);
							phase_d = '0;
						end
					end else begin
						state_d = FR_IDLE;
					end
				end
				default: state_d = FR_IDLE;
			endcase
		end
	end

	always_comb begin
		status_nxt.done   = latch;
		status_nxt.length = latch ? bidx_q : len_q;
		status_nxt.bytes  = latch ? pkt_gather : pkt_q;
		status_nxt.total  = latch ? cnt_q + CNT_W'(1) : cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
			phase_q <= '0;
			bidx_q  <= '0;
			len_q   <= '0;
			pkt_q   <= '0;
			cnt_q   <= '0;
		end else if (en) begin
			state_q <= state_d;
			phase_q <= phase_d;
			bidx_q  <= bidx_d;
			len_q   <= status_nxt.length;
			pkt_q   <= status_nxt.bytes;
			cnt_q   <= status_nxt.total;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_BYTES; i++) begin
			if (en && asm_we && bidx_q == IDX_W'(i)) asm_q[i] <= asm_wdata;
		end
	end

endmodule

[bench/dcc_decoder_checker.sv]
// result checker for the dcc capture packet decoder: watches the config port and both
// beat channels, predicts every result beat and compares it field by field
// depends on dccd_pkg
module dcc_decoder_checker
	import dccd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [TS_BITS-1:0] capture_time,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [1:0]         pulse_class,
	input  logic               toggle_edge,
	input  logic               packet_done,
	input  logic [IDX_W-1:0]   packet_length,
	input  logic [PKT_W-1:0]   packet_bytes,
	input  logic [CNT_W-1:0]   packets_total,
	output int                 pending_count,
	output int                 fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		pulse_class_t cls;
		logic         toggle;
		pkt_status_t  pkt;
	} pulse_report_t;

	cfg_t               cfg;
	logic [TS_BITS-1:0] last_stamp;
	frame_state_t       frame;
	logic [PH_W-1:0]    bit_count;
	logic [IDX_W-1:0]   byte_count;
	logic [7:0]         assembly [MAX_BYTES];
	logic [MIX_W-1:0]   mixed_seen;
	logic [PKT_W-1:0]   held_packet;
	logic [IDX_W-1:0]   held_length;
	logic [CNT_W-1:0]   held_total;
	pulse_report_t      pulse_reports [$];

	function automatic bit in_window(logic [TS_BITS-1:0] gap, logic [TS_BITS-1:0] centre);
		int unsigned lo, hi;
		lo = (centre > cfg.tolerance) ? centre - cfg.tolerance : 0;
		hi = centre + cfg.tolerance;
		return gap >= lo && gap <= hi;
	endfunction

	// one capture beat: classify the period, then step the framer
	function automatic pulse_report_t decode_capture(logic [TS_BITS-1:0] stamp);
		pulse_report_t      r;
		logic [TS_BITS-1:0] gap;
		pulse_class_t       cls;
		logic [7:0]         b;
		logic [PKT_W-1:0]   p;
		r = '0;
		gap = stamp - last_stamp;
		last_stamp = stamp;
		if (in_window(gap, cfg.one_period)) begin
			cls = CLS_ONE;
		end else if (in_window(gap, cfg.zero_period)) begin
			cls = CLS_ZERO;
		end else if (in_window(gap, cfg.mixed_period)) begin
			cls = CLS_MIXED;
			mixed_seen = mixed_seen + 1'b1;
			if (mixed_seen > cfg.mixed_flip_limit) begin
				mixed_seen = '0;
				r.toggle = 1'b1;
			end
			frame = FR_IDLE;
		end else begin
			cls = CLS_INVALID;
			frame = FR_IDLE;
		end

		case (frame)
			FR_IDLE: begin
				if (cls == CLS_ONE) begin
					frame = FR_PREAMBLE;
					bit_count = PH_W'(1);
				end
			end
			FR_PREAMBLE: begin
				if (cls == CLS_ONE) begin
					if (bit_count < cfg.preamble_min)
						bit_count = bit_count + 1'b1;
				end else if (cls == CLS_ZERO) begin
					if (bit_count < cfg.preamble_min) begin
						frame = FR_IDLE;
					end else begin
						frame = FR_DATA;
						bit_count = '0;
						byte_count = '0;
					end
				end
			end
			FR_SEPARATOR: begin
				if (cls == CLS_ZERO) begin
					if (byte_count <= MAX_BYTES - 1) begin
						frame = FR_DATA;
						bit_count = '0;
					end else begin
						frame = FR_IDLE;
					end
				end else if (cls == CLS_ONE) begin
					if (byte_count >= cfg.min_packet_bytes) begin
						p = '0;
						for (int i = 0; i < byte_count; i++)
							p[8*i +: 8] = assembly[i];
						held_packet = p;
						held_length = byte_count;
						held_total = held_total + 1'b1;
						r.pkt.done = 1'b1;
					end
					frame = FR_IDLE;
				end
			end
			default: begin
				if (byte_count < MAX_BYTES) begin
					b = (bit_count == 0) ? 8'h00 : {assembly[byte_count][6:0], 1'b0};
					if (cls == CLS_ONE)
						b[0] = 1'b1;
					assembly[byte_count] = b;
					bit_count = bit_count + 1'b1;
					if (bit_count == 8) begin
						frame = FR_SEPARATOR;
						byte_count = byte_count + 1'b1;
						bit_count = '0;
					end
				end else begin
					frame = FR_IDLE;
				end
			end
		endcase

		r.cls = cls;
		r.pkt.length = held_length;
		r.pkt.bytes = held_packet;
		r.pkt.total = held_total;
		return r;
	endfunction

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s expected 0x%0h actual 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pulse_report_t want;
		if (!arst_n) begin
			cfg.one_period = 16'd1856;
			cfg.zero_period = 16'd3200;
			cfg.mixed_period = 16'd2528;
			cfg.tolerance = 12'd100;
			cfg.preamble_min = 4'd12;
			cfg.mixed_flip_limit = 5'd20;
			cfg.min_packet_bytes = 3'd3;
			last_stamp = '0;
			frame = FR_IDLE;
			bit_count = '0;
			byte_count = '0;
			foreach (assembly[i])
				assembly[i] = '0;
			mixed_seen = '0;
			held_packet = '0;
			held_length = '0;
			held_total = '0;
			pulse_reports.delete();
			fail_count = 0;
			pending_count <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pulse_reports.size() == 0) begin
					$error("result beat with no capture beat waiting");
					fail_count++;
				end else begin
					want = pulse_reports.pop_front();
					check_field("pulse_class", want.cls, pulse_class);
					check_field("toggle_edge", want.toggle, toggle_edge);
					check_field("packet_done", want.pkt.done, packet_done);
					check_field("packet_length", want.pkt.length, packet_length);
					check_field("packet_bytes", want.pkt.bytes, packet_bytes);
					check_field("packets_total", want.pkt.total, packets_total);
				end
			end
			if (cfg_wr_en) begin
				case (reg_index_t'(cfg_index))
					REG_ONE_PERIOD:   cfg.one_period = cfg_data;
					REG_ZERO_PERIOD:  cfg.zero_period = cfg_data;
					REG_MIXED_PERIOD: cfg.mixed_period = cfg_data;
					REG_TOLERANCE:    cfg.tolerance = cfg_data[TOL_W-1:0];
					REG_PREAMBLE_MIN: cfg.preamble_min = cfg_data[PRE_W-1:0];
					REG_MIXED_LIMIT:  cfg.mixed_flip_limit = cfg_data[MIX_W-1:0];
					REG_MIN_BYTES:    cfg.min_packet_bytes = cfg_data[MINB_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				pulse_reports.push_back(decode_capture(capture_time));
			pending_count <= pulse_reports.size();
		end
	end

endmodule

[bench/dcc_capture_packet_decoder_test.sv]
// top of the dcc capture packet decoder bench: clock, reset, config writes, capture beats
// built from dcc bit periods, random receiver stalls, watchdog and verdict
// depends on dccd_pkg, dcc_capture_packet_decoder and dcc_decoder_checker
module dcc_capture_packet_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;
	import dccd_pkg::*;

	// register values after reset
	localparam cfg_t RESET_CFG = '{16'd1856, 16'd3200, 16'd2528, 12'd100, 4'd12, 5'd20, 3'd3};
	// cycles with no accepted beat before the run is declared hung
	localparam int IDLE_LIMIT = 2000;
	// random items per config phase, a packet in flight at the end runs past it
	localparam int PHASE_ITEMS = 62;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [TS_BITS-1:0] capture_time = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         pulse_class;
	logic               toggle_edge;
	logic               packet_done;
	logic [IDX_W-1:0]   packet_length;
	logic [PKT_W-1:0]   packet_bytes;
	logic [CNT_W-1:0]   packets_total;
	int                 pending_count;
	int                 fail_count;

	// sender side bookkeeping
	cfg_t               settings = RESET_CFG;
	logic [TS_BITS-1:0] stamp = '0;
	int                 items_sent = 0;
	int                 burst_left = 1;

	// receiver stall pattern
	int                 stall_span = 0;
	int                 stall_pct = 0;

	int                 idle_cycles = 0;

	always #10 clk = ~clk;

	dcc_capture_packet_decoder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.capture_time  (capture_time),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pulse_class   (pulse_class),
		.toggle_edge   (toggle_edge),
		.packet_done   (packet_done),
		.packet_length (packet_length),
		.packet_bytes  (packet_bytes),
		.packets_total (packets_total)
	);

	dcc_decoder_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.capture_time  (capture_time),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pulse_class   (pulse_class),
		.toggle_edge   (toggle_edge),
		.packet_done   (packet_done),
		.packet_length (packet_length),
		.packet_bytes  (packet_bytes),
		.packets_total (packets_total),
		.pending_count (pending_count),
		.fail_count    (fail_count)
	);

	// receiver: stall probability is redrawn after each random span, from never to almost always
	always @(posedge clk) begin
		if (stall_span == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pct <= 0;
				1: stall_pct <= 25;
				2: stall_pct <= 60;
				default: stall_pct <= 90;
			endcase
			stall_span <= $urandom_range(50, 200);
		end else begin
			stall_span <= stall_span - 1;
		end
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// watchdog: any accepted beat or config write counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("dcc_capture_packet_decoder: mismatch");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// one capture beat; valid stays high across a burst, an idle gap follows each burst
	// so valid is never dropped and raised in the same step
	task automatic send_capture(logic [TS_BITS-1:0] value);
		int gap;
		in_valid <= 1'b1;
		capture_time <= value;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			gap = $urandom_range(1, 20);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			// now and then a long burst with no idling at all
			if ($urandom_range(0, 7) == 0)
				burst_left = $urandom_range(40, 120);
			else
				burst_left = $urandom_range(1, 12);
		end
	endtask

	// next capture lands the given number of ticks after the last one, wrapping at 16 bits
	task automatic send_gap(logic [TS_BITS-1:0] ticks);
		stamp = stamp + ticks;
		send_capture(stamp);
	endtask

	// a period of the wanted class under the current settings; invalid gets any value,
	// the others fall inside the window, now and then right on its edge
	function automatic logic [TS_BITS-1:0] period_for(pulse_class_t c, bit exact);
		int centre, span, p;
		case (c)
			CLS_ONE:   centre = settings.one_period;
			CLS_ZERO:  centre = settings.zero_period;
			CLS_MIXED: centre = settings.mixed_period;
			default:   return TS_BITS'($urandom);
		endcase
		span = settings.tolerance;
		if (exact)
			p = centre;
		else if ($urandom_range(0, 7) == 0)
			p = $urandom_range(0, 1) ? centre + span : centre - span;
		else
			p = centre - span + $urandom_range(0, 2 * span);
		// window clamps at zero
		if (p < 0)
			p = 0;
		return TS_BITS'(p);
	endfunction

	task automatic send_symbol(pulse_class_t c, bit exact);
		send_gap(period_for(c, exact));
	endtask

	// preamble ones, start zero, bytes msb first with zero separators, one as end bit;
	// an optional mixed or invalid period can be slipped in to break the frame
	task automatic send_packet(int n_pre, int nbytes, logic [63:0] data, int noise_at,
			bit exact);
		pulse_class_t symbols [$];
		pulse_class_t noise;
		repeat (n_pre) symbols.push_back(CLS_ONE);
		symbols.push_back(CLS_ZERO);
		for (int b = 0; b < nbytes; b++) begin
			for (int k = 7; k >= 0; k--) begin
				if (data[8*b + k])
					symbols.push_back(CLS_ONE);
				else
					symbols.push_back(CLS_ZERO);
			end
			if (b == nbytes - 1)
				symbols.push_back(CLS_ONE);
			else
				symbols.push_back(CLS_ZERO);
		end
		if (noise_at >= 0 && noise_at < symbols.size()) begin
			if ($urandom_range(0, 1))
				noise = CLS_MIXED;
			else
				noise = CLS_INVALID;
			symbols.insert(noise_at, noise);
		end
		foreach (symbols[i])
			send_symbol(symbols[i], exact);
	endtask

	// config writes go back to back; enable drops after the last one
	task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic apply_settings(cfg_t s);
		settings = s;
		write_reg(REG_ONE_PERIOD, s.one_period);
		write_reg(REG_ZERO_PERIOD, s.zero_period);
		write_reg(REG_MIXED_PERIOD, s.mixed_period);
		write_reg(REG_TOLERANCE, CFG_W'(s.tolerance));
		write_reg(REG_PREAMBLE_MIN, CFG_W'(s.preamble_min));
		write_reg(REG_MIXED_LIMIT, CFG_W'(s.mixed_flip_limit));
		write_reg(REG_MIN_BYTES, CFG_W'(s.min_packet_bytes));
		cfg_wr_en <= 1'b0;
	endtask

	// hold the sender until every result beat is back, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		cfg_t s;
		int   r, n_pre, nbytes, noise_at, target;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings: equal timestamps give a zero period
		send_gap(16'd0);
		// one, zero and mixed at their centres, and the one window at both edges and just outside
		send_symbol(CLS_ONE, 1'b1);
		send_gap(settings.one_period - settings.tolerance);
		send_gap(settings.one_period + settings.tolerance);
		send_gap(settings.one_period - settings.tolerance - 1'b1);
		send_symbol(CLS_ZERO, 1'b1);
		send_symbol(CLS_MIXED, 1'b1);
		send_gap(settings.mixed_period + settings.tolerance);
		// largest difference, then the top timestamp value
		send_gap('1);
		stamp = '1;
		send_capture(stamp);

		// directed short packet: one preamble bit, a single byte, latched
		drain();
		s = RESET_CFG;
		s.preamble_min = 4'd1;
		s.min_packet_bytes = 3'd1;
		apply_settings(s);
		send_packet(1, 1, 64'hA5, -1, 1'b1);

		// random phases, each under its own settings with the sender held off between
		for (int phase_idx = 0; phase_idx < 8; phase_idx++) begin
			case (phase_idx)
				0: s = RESET_CFG;
				// zero tolerance, one window sits on zero, every mixed period flips
				1: s = '{16'd0, 16'hFFFF, 16'h8000, 12'd0, 4'd1, 5'd0, 3'd1};
				// widest tolerance: windows clamp low and overlap, zero window passes the top,
				// longest preamble, no flip ever, longest minimum packet
				2: s = '{16'd100, 16'hFFFF, 16'd3000, 12'hFFF, 4'd15, 5'd31, 3'd7};
				default: begin
					s.tolerance = TOL_W'($urandom_range(0, 400));
					s.one_period = TS_BITS'($urandom_range(500, 8000));
					s.zero_period = TS_BITS'(s.one_period + 2 * s.tolerance + 1
						+ $urandom_range(0, 4000));
					s.mixed_period = TS_BITS'(s.zero_period + 2 * s.tolerance + 1
						+ $urandom_range(0, 4000));
					s.preamble_min = PRE_W'($urandom_range(1, 15));
					s.mixed_flip_limit = MIX_W'($urandom_range(0, 31));
					s.min_packet_bytes = MINB_W'($urandom_range(1, 7));
				end
			endcase
			drain();
			apply_settings(s);

			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					// mostly well-formed packets, some with short preambles, some overflowing
					if ($urandom_range(0, 4) == 0)
						n_pre = $urandom_range(0, settings.preamble_min);
					else
						n_pre = settings.preamble_min + $urandom_range(0, 3);
					if ($urandom_range(0, 9) == 0)
						nbytes = MAX_BYTES + 1;
					else
						nbytes = $urandom_range(1, MAX_BYTES);
					if ($urandom_range(0, 7) == 0)
						noise_at = $urandom_range(0, 80);
					else
						noise_at = -1;
					send_packet(n_pre, nbytes, {$urandom, $urandom}, noise_at, 1'b0);
				end else if (r < 80) begin
					send_symbol(pulse_class_t'($urandom_range(0, 3)), 1'b0);
				end else if (r < 90) begin
					// run of mixed periods of random length, up to two more than the flip limit
					repeat ($urandom_range(1, settings.mixed_flip_limit + 2))
						send_symbol(CLS_MIXED, 1'b0);
				end else begin
					// jump to an arbitrary timestamp
					stamp = TS_BITS'($urandom);
					send_capture(stamp);
				end
			end
		end

		drain();
		if (fail_count == 0)
			$display("dcc_capture_packet_decoder: match");
		else
			$display("dcc_capture_packet_decoder: mismatch");
		$finish;
	end

endmodule

[dcc_capture_packet_decoder.f]
design/dccd_pkg.sv
design/dccd_classify.sv
design/dccd_framer.sv
design/dcc_capture_packet_decoder.sv
bench/dcc_decoder_checker.sv
bench/dcc_capture_packet_decoder_test.sv
